@@ hdl/hcmm_pkg.sv @@
package hcmm_pkg;

  localparam int CART_BANKS = 4;
  localparam int WORK_BANKS = 7;

  localparam int VRAM_BASE  = 0;
  localparam int CART_BASE  = VRAM_BASE + 2 * 8192;
  localparam int WLOW_BASE  = CART_BASE + CART_BANKS * 8192;
  localparam int WHIGH_BASE = WLOW_BASE + 4096;
  localparam int OAM_BASE   = WHIGH_BASE + WORK_BANKS * 4096;
  localparam int DMEM_DEPTH = OAM_BASE + 160;
  localparam int DMEM_AW    = $clog2(DMEM_DEPTH);

  localparam logic [2:0] CART_NO_BANK = 3'd4;

  localparam logic [7:0] IO_JOYP = 8'h00;
  localparam logic [7:0] IO_DIV  = 8'h04;
  localparam logic [7:0] IO_TAC  = 8'h07;
  localparam logic [7:0] IO_IF   = 8'h0F;
  localparam logic [7:0] IO_LCDC = 8'h40;
  localparam logic [7:0] IO_STAT = 8'h41;
  localparam logic [7:0] IO_LY   = 8'h44;
  localparam logic [7:0] IO_DMA  = 8'h46;

  localparam logic [7:0] LCDC_RESET = 8'h91;
  localparam logic [7:0] TAC_FILL   = 8'd248;
  localparam logic [7:0] IF_FILL    = 8'hE0;
  localparam logic [7:0] DMA_LIMIT  = 8'hE0;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  localparam logic [1:0] LCD_EV_NONE = 2'd0;
  localparam logic [1:0] LCD_EV_OFF  = 2'd1;
  localparam logic [1:0] LCD_EV_ON   = 2'd2;

  typedef enum logic [2:0] {
    CFG_ROM_BANK   = 3'd0,
    CFG_VIDEO_BANK = 3'd1,
    CFG_CART_EN    = 3'd2,
    CFG_CART_SEL   = 3'd3,
    CFG_WORK_BANK  = 3'd4
  } cfg_index_e;

  typedef enum logic [1:0] {
    SRC_IMM  = 2'd0,
    SRC_DMEM = 2'd1,
    SRC_IO   = 2'd2
  } rd_src_e;

  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] off;
    logic [7:0] wdata;
  } io_req_t;

  function automatic logic [7:0] io_reset_value(logic [7:0] off);
    logic [7:0] v;
    v = 8'h00;
    case (off)
      8'h10: v = 8'h80;
      8'h11: v = 8'hBF;
      8'h12: v = 8'hF3;
      8'h14: v = 8'hBF;
      8'h16: v = 8'h3F;
      8'h19: v = 8'hBF;
      8'h1A: v = 8'h7F;
      8'h1B: v = 8'hFF;
      8'h1C: v = 8'h9F;
      8'h1E: v = 8'hBF;
      8'h20: v = 8'hFF;
      8'h23: v = 8'hBF;
      8'h24: v = 8'h77;
      8'h25: v = 8'hF3;
      8'h26: v = 8'hF1;
      8'h40: v = 8'h91;
      8'h47: v = 8'hFC;
      8'h48: v = 8'hFF;
      8'h49: v = 8'hFF;
      8'h03, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E,
      8'h15, 8'h1F, 8'h27, 8'h28, 8'h29: v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/hcmm_io_file.sv @@
module hcmm_io_file
  import hcmm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  io_req_t    req_i,
  output logic [7:0] rdata_o
);

  logic [7:0]   mem [256];
  logic [255:0] valid_q;
  logic [7:0]   rd_q;
  logic         rd_valid_q;
  logic [7:0]   rd_off_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.off] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q     <= mem[req_i.off];
      rd_off_q <= req_i.off;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.off] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.off];
      end
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : io_reset_value(rd_off_q);

endmodule

@@ hdl/handheld_console_memory_map.sv @@
// byte bus decoder for a handheld console address space
// input channel: in_valid_i / in_stall_o with func, address, write data and
//   the video, dma, joypad, divider and scan line status of the access
// output channel: out_valid_o / out_stall_i, one result per access
// config channel: cfg_valid_i / cfg_ready_o, always ready, write only
// an access is decoded at accept, where it touches the data memory or the io
//   register file; the working stage then loads the output register when free
// a new access is accepted only after the previous one has left the working
//   stage; the data memory is read only at accept
// rom area reads return rom_fetch and the external rom address
// a stalled result holds in the output register; the finished access waits
//   in the working stage, and the input stalls until it moves out
// reset clears control state and restores io power-on values through
//   per-register valid bits; ram contents are undefined until written
module handheld_console_memory_map
  import hcmm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [1:0]  video_mode_i,
  input  logic        dma_busy_i,
  input  logic [7:0]  buttons_i,
  input  logic [7:0]  divider_high_i,
  input  logic [7:0]  scan_line_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        rom_fetch_o,
  output logic [20:0] rom_address_o,
  output logic        divider_clear_o,
  output logic [1:0]  lcd_event_o,
  output logic        dma_request_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic [6:0] rom_bank_q;
  logic       video_bank_q;
  logic       cart_en_q;
  logic [2:0] cart_sel_q;
  logic [2:0] work_bank_q;

  logic [7:0] joyp_q;
  logic [7:0] lcdc_q;
  logic [7:0] stat_q;
  logic [7:0] joyp_d;
  logic [7:0] lcdc_d;
  logic [7:0] stat_d;

  logic busy_q;
  logic busy_d;
  logic accept;
  logic finish;

  rd_src_e     src_q;
  rd_src_e     src_d;
  logic [7:0]  imm_q;
  logic [7:0]  imm_d;
  logic        rom_fetch_q;
  logic        rom_fetch_d;
  logic [20:0] rom_addr_q;
  logic [20:0] rom_addr_d;
  logic        div_clr_q;
  logic        div_clr_d;
  logic [1:0]  lcd_ev_q;
  logic [1:0]  lcd_ev_d;
  logic        dma_req_q;
  logic        dma_req_d;

  logic               out_valid_q;
  logic               out_valid_d;
  logic [7:0]         out_read_data_q;
  logic               out_rom_fetch_q;
  logic [20:0]        out_rom_addr_q;
  logic               out_div_clr_q;
  logic [1:0]         out_lcd_ev_q;
  logic               out_dma_req_q;
  logic [7:0]         stage_data;

  logic [7:0]         dmem [DMEM_DEPTH];
  logic [7:0]         dmem_rdata_q;
  logic               dmem_re;
  logic               dmem_we;
  logic [DMEM_AW-1:0] dmem_addr;

  io_req_t    io_req;
  logic [7:0] io_rdata;

  logic [3:0] nib;
  logic [7:0] off;
  logic       cart_ok;
  logic       obj_ok;

  assign accept      = in_valid_i && !busy_q;
  assign finish      = busy_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = busy_q;
  assign cfg_ready_o = 1'b1;

  assign nib     = address_i[15:12];
  assign off     = address_i[7:0];
  assign cart_ok = cart_en_q && (cart_sel_q != CART_NO_BANK) &&
                   (32'(cart_sel_q) < CART_BANKS);
  assign obj_ok  = !dma_busy_i && (video_mode_i == MODE_HBLANK ||
                   video_mode_i == MODE_VBLANK);

  always_comb begin
    src_d       = SRC_IMM;
    imm_d       = func_i ? 8'h00 : 8'hFF;
    rom_fetch_d = 1'b0;
    rom_addr_d  = '0;
    div_clr_d   = 1'b0;
    lcd_ev_d    = LCD_EV_NONE;
    dma_req_d   = 1'b0;
    dmem_re     = 1'b0;
    dmem_we     = 1'b0;
    dmem_addr   = '0;
    io_req      = '0;
    joyp_d      = joyp_q;
    lcdc_d      = lcdc_q;
    stat_d      = stat_q;
    io_req.off   = off;
    io_req.wdata = write_data_i;
    if (nib < 4'h8) begin
      imm_d = 8'h00;
      if (!func_i) begin
        rom_fetch_d = 1'b1;
        rom_addr_d  = (nib < 4'h4) ? {5'b0, address_i} : {rom_bank_q, address_i[13:0]};
      end
    end else if (nib == 4'h8 || nib == 4'h9) begin
      dmem_addr = DMEM_AW'(VRAM_BASE) + DMEM_AW'({video_bank_q, address_i[12:0]});
      if (video_mode_i != MODE_XFER) begin
        dmem_we = func_i;
        dmem_re = !func_i;
      end
    end else if (nib == 4'hA || nib == 4'hB) begin
      dmem_addr = DMEM_AW'(CART_BASE) + DMEM_AW'({cart_sel_q, address_i[12:0]});
      if (cart_ok) begin
        dmem_we = func_i;
        dmem_re = !func_i;
      end
    end else if (nib == 4'hC || nib == 4'hE) begin
      dmem_addr = DMEM_AW'(WLOW_BASE) + DMEM_AW'(address_i[11:0]);
      dmem_we   = func_i;
      dmem_re   = !func_i;
    end else if (nib == 4'hD || address_i <= 16'hFDFF) begin
      dmem_addr = DMEM_AW'(WHIGH_BASE) + DMEM_AW'({work_bank_q, address_i[11:0]});
      if (32'(work_bank_q) < WORK_BANKS) begin
        dmem_we = func_i;
        dmem_re = !func_i;
      end
    end else if (address_i >= 16'hFF00) begin
      if (func_i) begin
        case (off)
          IO_JOYP: joyp_d = write_data_i;
          IO_DIV:  div_clr_d = 1'b1;
          IO_TAC: begin
            io_req.we    = 1'b1;
            io_req.wdata = write_data_i | TAC_FILL;
          end
          IO_IF: begin
            io_req.we    = 1'b1;
            io_req.wdata = write_data_i | IF_FILL;
          end
          IO_LCDC: begin
            lcdc_d = write_data_i;
            if (!write_data_i[7] && lcdc_q[7]) begin
              stat_d   = {stat_q[7:2], 2'b00};
              lcd_ev_d = LCD_EV_OFF;
            end else if (write_data_i[7] && !lcdc_q[7]) begin
              stat_d   = stat_q | 8'h02;
              lcd_ev_d = LCD_EV_ON;
            end
          end
          IO_STAT: stat_d = {1'b1, write_data_i[6:3], stat_q[2:0]};
          IO_LY:   ;
          IO_DMA: begin
            io_req.we = 1'b1;
            dma_req_d = write_data_i < DMA_LIMIT;
          end
          default: io_req.we = 1'b1;
        endcase
      end else begin
        case (off)
          IO_JOYP: begin
            if (!joyp_q[4]) begin
              imm_d = {joyp_q[7:4], buttons_i[3:0]};
            end else if (!joyp_q[5]) begin
              imm_d = {joyp_q[7:4], buttons_i[7:4]};
            end else begin
              imm_d = 8'hFF;
            end
          end
          IO_LY:   imm_d = scan_line_i;
          IO_DIV:  imm_d = divider_high_i;
          IO_LCDC: imm_d = lcdc_q;
          IO_STAT: imm_d = stat_q;
          default: begin
            src_d     = SRC_IO;
            io_req.re = 1'b1;
          end
        endcase
      end
    end else if (address_i <= 16'hFE9F) begin
      dmem_addr = DMEM_AW'(OAM_BASE) + DMEM_AW'(off);
      if (obj_ok) begin
        dmem_we = func_i;
        dmem_re = !func_i;
      end
    end
    if (dmem_re) begin
      src_d = SRC_DMEM;
    end
    if (!accept) begin
      dmem_re   = 1'b0;
      dmem_we   = 1'b0;
      io_req.we = 1'b0;
      io_req.re = 1'b0;
      joyp_d    = joyp_q;
      lcdc_d    = lcdc_q;
      stat_d    = stat_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dmem_we) begin
      dmem[dmem_addr] <= write_data_i;
    end
    if (dmem_re) begin
      dmem_rdata_q <= dmem[dmem_addr];
    end
  end

  hcmm_io_file u_io_file (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (io_req),
    .rdata_o (io_rdata)
  );

  always_comb begin
    case (src_q)
      SRC_DMEM: stage_data = dmem_rdata_q;
      SRC_IO:   stage_data = io_rdata;
      default:  stage_data = imm_q;
    endcase
  end

  assign busy_d      = accept ? 1'b1 : (finish ? 1'b0 : busy_q);
  assign out_valid_d = finish || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bank_q   <= 7'd1;
      video_bank_q <= 1'b0;
      cart_en_q    <= 1'b0;
      cart_sel_q   <= CART_NO_BANK;
      work_bank_q  <= 3'd0;
      joyp_q       <= 8'h00;
      lcdc_q       <= LCDC_RESET;
      stat_q       <= 8'h00;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ROM_BANK:   rom_bank_q   <= cfg_data_i[6:0];
          CFG_VIDEO_BANK: video_bank_q <= cfg_data_i[0];
          CFG_CART_EN:    cart_en_q    <= cfg_data_i[0];
          CFG_CART_SEL:   cart_sel_q   <= cfg_data_i[2:0];
          CFG_WORK_BANK:  work_bank_q  <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      joyp_q      <= joyp_d;
      lcdc_q      <= lcdc_d;
      stat_q      <= stat_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q       <= src_d;
      imm_q       <= imm_d;
      rom_fetch_q <= rom_fetch_d;
      rom_addr_q  <= rom_addr_d;
      div_clr_q   <= div_clr_d;
      lcd_ev_q    <= lcd_ev_d;
      dma_req_q   <= dma_req_d;
    end
    if (finish) begin
      out_read_data_q <= stage_data;
      out_rom_fetch_q <= rom_fetch_q;
      out_rom_addr_q  <= rom_addr_q;
      out_div_clr_q   <= div_clr_q;
      out_lcd_ev_q    <= lcd_ev_q;
      out_dma_req_q   <= dma_req_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_read_data_q;
  assign rom_fetch_o     = out_rom_fetch_q;
  assign rom_address_o   = out_rom_addr_q;
  assign divider_clear_o = out_div_clr_q;
  assign lcd_event_o     = out_lcd_ev_q;
  assign dma_request_o   = out_dma_req_q;

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("transfer accepted without entering the working stage");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_read_data_q))
    else $error("stalled result changed");

  a_rom_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_rom_fetch_q |-> out_read_data_q == 8'h00)
    else $error("rom fetch with nonzero read data");

  a_lcd_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_lcd_ev_q != 2'd3)
    else $error("illegal lcd event code");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import hcmm_pkg::*;

  typedef struct {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [1:0]  mode;
    logic        dma;
    logic [7:0]  buttons;
    logic [7:0]  divh;
    logic [7:0]  line;
  } access_t;

  typedef struct {
    logic [7:0]  rdata;
    logic        rom_fetch;
    logic [20:0] rom_addr;
    logic        div_clear;
    logic [1:0]  lcd_ev;
    logic        dma_req;
  } bus_result_t;

  class memory_map_scoreboard;
    logic [7:0]  ram_bytes[int];
    logic [7:0]  io_file[256];
    logic [6:0]  rom_bank;
    logic        video_bank;
    logic        cart_en;
    logic [2:0]  cart_sel;
    logic [2:0]  work_bank;
    bus_result_t awaited[$];
    int          errors;

    function new();
      for (int i = 0; i < 256; i++) io_file[i] = io_reset_value(i[7:0]);
      rom_bank   = 7'd1;
      video_bank = 1'b0;
      cart_en    = 1'b0;
      cart_sel   = CART_NO_BANK;
      work_bank  = 3'd0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_index_e idx, logic [7:0] d);
      case (idx)
        CFG_ROM_BANK:   rom_bank = d[6:0];
        CFG_VIDEO_BANK: video_bank = d[0];
        CFG_CART_EN:    cart_en = d[0];
        CFG_CART_SEL:   cart_sel = d[2:0];
        CFG_WORK_BANK:  work_bank = d[2:0];
        default: ;
      endcase
    endfunction

    // flat ram byte index for an address of 8000 up, or -1 when locked, io or unmapped
    function int mem_key(logic [15:0] a, logic [1:0] mode, logic dma);
      int base;
      base = 0;
      case (a[15:12])
        4'h8, 4'h9: return (mode != MODE_XFER) ? video_bank * 8192 + a[12:0] : -1;
        4'hA, 4'hB: begin
          base = 2 * 8192;
          if (cart_en && cart_sel != CART_NO_BANK && cart_sel < CART_BANKS)
            return base + cart_sel * 8192 + a[12:0];
          return -1;
        end
        4'hC, 4'hE: return 2 * 8192 + CART_BANKS * 8192 + a[11:0];
        default: ;
      endcase
      if (a[15:12] == 4'hD || a <= 16'hFDFF) begin
        base = 2 * 8192 + CART_BANKS * 8192 + 4096;
        return (work_bank < WORK_BANKS) ? base + work_bank * 4096 + a[11:0] : -1;
      end
      if (a >= 16'hFF00 || a > 16'hFE9F) return -1;
      if (dma || !(mode == MODE_HBLANK || mode == MODE_VBLANK)) return -1;
      return 2 * 8192 + CART_BANKS * 8192 + 4096 + WORK_BANKS * 4096 + a[7:0];
    endfunction

    function void note_access(access_t t);
      bus_result_t r;
      int          key;
      logic [7:0]  off;
      logic [7:0]  rd;
      r = '{default: '0};
      rd = 8'hFF;
      off = t.addr[7:0];
      if (t.addr[15:12] < 4'h8) begin
        if (!t.wr) begin
          r.rom_fetch = 1'b1;
          r.rom_addr = (t.addr[15:12] < 4'h4) ? 21'(t.addr)
                       : 21'(rom_bank * 32'h4000 + t.addr - 32'h4000);
        end
        awaited.push_back(r);
        return;
      end
      key = mem_key(t.addr, t.mode, t.dma);
      if (key >= 0) begin
        if (t.wr) ram_bytes[key] = t.wdata;
        else rd = ram_bytes.exists(key) ? ram_bytes[key] : 8'h00;
      end else if (t.addr >= 16'hFF00) begin
        if (!t.wr) begin
          case (off)
            IO_JOYP: begin
              if (!io_file[IO_JOYP][4]) rd = {io_file[IO_JOYP][7:4], t.buttons[3:0]};
              else if (!io_file[IO_JOYP][5]) rd = {io_file[IO_JOYP][7:4], t.buttons[7:4]};
              else rd = 8'hFF;
            end
            IO_LY:  rd = t.line;
            IO_DIV: rd = t.divh;
            default: rd = io_file[off];
          endcase
        end else begin
          case (off)
            IO_TAC: io_file[IO_TAC] = t.wdata | TAC_FILL;
            IO_DIV: r.div_clear = 1'b1;
            IO_IF:  io_file[IO_IF] = t.wdata | IF_FILL;
            IO_LCDC: begin
              if (!t.wdata[7] && io_file[IO_LCDC][7]) begin
                io_file[IO_STAT] = io_file[IO_STAT] & 8'hFC;
                r.lcd_ev = LCD_EV_OFF;
              end
              if (t.wdata[7] && !io_file[IO_LCDC][7]) begin
                io_file[IO_STAT] = io_file[IO_STAT] | 8'h02;
                r.lcd_ev = LCD_EV_ON;
              end
              io_file[IO_LCDC] = t.wdata;
            end
            IO_STAT: io_file[IO_STAT] = (io_file[IO_STAT] & 8'h07) | (t.wdata & 8'hF8) | 8'h80;
            IO_LY: ;
            IO_DMA: begin
              io_file[IO_DMA] = t.wdata;
              r.dma_req = t.wdata < DMA_LIMIT;
            end
            default: io_file[off] = t.wdata;
          endcase
        end
      end
      if (!t.wr) r.rdata = rd;
      awaited.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(bus_result_t got);
      bus_result_t w;
      if (awaited.size() == 0) begin
        report("extra result", 32'd1, 32'd0);
        return;
      end
      w = awaited.pop_front();
      if (!w.rom_fetch && got.rdata !== w.rdata)
        report("read_data", 32'(got.rdata), 32'(w.rdata));
      if (got.rom_fetch !== w.rom_fetch)
        report("rom_fetch", 32'(got.rom_fetch), 32'(w.rom_fetch));
      if (got.rom_addr !== w.rom_addr)
        report("rom_address", 32'(got.rom_addr), 32'(w.rom_addr));
      if (got.div_clear !== w.div_clear)
        report("divider_clear", 32'(got.div_clear), 32'(w.div_clear));
      if (got.lcd_ev !== w.lcd_ev)
        report("lcd_event", 32'(got.lcd_ev), 32'(w.lcd_ev));
      if (got.dma_req !== w.dma_req)
        report("dma_request", 32'(got.dma_req), 32'(w.dma_req));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        func_i;
  logic [15:0] address_i;
  logic [7:0]  write_data_i;
  logic [1:0]  video_mode_i;
  logic        dma_busy_i;
  logic [7:0]  buttons_i;
  logic [7:0]  divider_high_i;
  logic [7:0]  scan_line_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  read_data_o;
  logic        rom_fetch_o;
  logic [20:0] rom_address_o;
  logic        divider_clear_o;
  logic [1:0]  lcd_event_o;
  logic        dma_request_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  memory_map_scoreboard sb = new();
  bit          written_keys[int];
  logic [15:0] written_addrs[$];
  int          burst_left;

  handheld_console_memory_map dut (.*);

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    access_t t;
    bus_result_t r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      t = '{func_i, address_i, write_data_i, video_mode_i, dma_busy_i,
            buttons_i, divider_high_i, scan_line_i};
      sb.note_access(t);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      r = '{read_data_o, rom_fetch_o, rom_address_o, divider_clear_o,
            lcd_event_o, dma_request_o};
      sb.check_result(r);
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) sb.set_reg(cfg_index_e'(cfg_index_i), cfg_data_i);
  end

  task send_access(access_t t);
    in_valid_i     <= 1'b1;
    func_i         <= t.wr;
    address_i      <= t.addr;
    write_data_i   <= t.wdata;
    video_mode_i   <= t.mode;
    dma_busy_i     <= t.dma;
    buttons_i      <= t.buttons;
    divider_high_i <= t.divh;
    scan_line_i    <= t.line;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // turns a read of never-written ram into a write so only stored bytes are read back
  task issue(logic wr, logic [15:0] a, logic [7:0] d, logic [1:0] mode, logic dma);
    access_t t;
    int key;
    key = sb.mem_key(a, mode, dma);
    if (a[15:12] >= 4'h8 && key >= 0 && !wr && !written_keys.exists(key)) wr = 1'b1;
    if (a[15:12] >= 4'h8 && key >= 0 && wr) begin
      written_keys[key] = 1'b1;
      if (written_addrs.size() > 64) void'(written_addrs.pop_front());
      written_addrs.push_back(a);
    end
    t = '{wr, a, d, mode, dma, 8'($urandom), 8'($urandom), 8'($urandom_range(0, 153))};
    send_access(t);
  endtask

  task random_access();
    logic [15:0] a;
    logic [7:0]  specials[10];
    int          r;
    specials = '{IO_JOYP, IO_DIV, IO_TAC, IO_IF, IO_LCDC, IO_STAT, IO_LY, IO_DMA,
                 8'h80, 8'hFF};
    r = $urandom_range(0, 99);
    if (r < 10) a = 16'($urandom_range(16'h0000, 16'h7FFF));
    else if (r < 25) a = 16'($urandom_range(16'h8000, 16'h9FFF));
    else if (r < 35) a = 16'($urandom_range(16'hA000, 16'hBFFF));
    else if (r < 55) a = 16'($urandom_range(16'hC000, 16'hFDFF));
    else if (r < 65) a = 16'($urandom_range(16'hFE00, 16'hFEFF));
    else if ($urandom_range(0, 1)) a = {8'hFF, specials[$urandom_range(0, 9)]};
    else a = {8'hFF, 8'($urandom)};
    if (written_addrs.size() > 0 && $urandom_range(0, 99) < 35)
      a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
    issue(1'($urandom_range(0, 1)), a, 8'($urandom), 2'($urandom_range(0, 3)),
          $urandom_range(0, 9) == 0);
  endtask

  task wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task write_reg(cfg_index_e idx, logic [7:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task directed();
    issue(1'b0, 16'h0000, 8'h00, MODE_HBLANK, 1'b0);
    issue(1'b0, 16'h3FFF, 8'h00, MODE_HBLANK, 1'b0);
    issue(1'b0, 16'h4000, 8'h00, MODE_HBLANK, 1'b0);
    issue(1'b0, 16'h7FFF, 8'h00, MODE_HBLANK, 1'b0);
    issue(1'b1, 16'h2000, 8'hA5, MODE_HBLANK, 1'b0);
    issue(1'b1, 16'h9FFF, 8'h5A, MODE_VBLANK, 1'b0);
    issue(1'b0, 16'h9FFF, 8'h00, MODE_XFER, 1'b0);
    issue(1'b0, 16'h9FFF, 8'h00, MODE_HBLANK, 1'b0);
    issue(1'b0, 16'hA000, 8'h00, MODE_HBLANK, 1'b0);
    issue(1'b1, 16'hC123, 8'hFF, MODE_HBLANK, 1'b0);
    issue(1'b0, 16'hE123, 8'h00, MODE_HBLANK, 1'b0);
    issue(1'b1, 16'hFDFF, 8'h3C, MODE_HBLANK, 1'b0);
    issue(1'b0, 16'hDDFF, 8'h00, MODE_HBLANK, 1'b0);
    issue(1'b1, 16'hFE9F, 8'h77, MODE_HBLANK, 1'b0);
    issue(1'b0, 16'hFE9F, 8'h00, MODE_HBLANK, 1'b1);
    issue(1'b0, 16'hFE9F, 8'h00, 2'd2, 1'b0);
    issue(1'b0, 16'hFEA0, 8'h00, MODE_VBLANK, 1'b0);
    issue(1'b1, {8'hFF, IO_JOYP}, 8'h20, MODE_HBLANK, 1'b0);
    issue(1'b0, {8'hFF, IO_JOYP}, 8'h00, MODE_HBLANK, 1'b0);
    issue(1'b1, {8'hFF, IO_JOYP}, 8'h10, MODE_HBLANK, 1'b0);
    issue(1'b0, {8'hFF, IO_JOYP}, 8'h00, MODE_HBLANK, 1'b0);
    issue(1'b1, {8'hFF, IO_DIV}, 8'h12, MODE_HBLANK, 1'b0);
    issue(1'b1, {8'hFF, IO_LCDC}, 8'h11, MODE_HBLANK, 1'b0);
    issue(1'b1, {8'hFF, IO_LCDC}, 8'h80, MODE_HBLANK, 1'b0);
    issue(1'b1, {8'hFF, IO_DMA}, 8'hDF, MODE_HBLANK, 1'b0);
  endtask

  initial begin
    logic [7:0] settings[5][5];
    settings = '{'{8'd0, 8'd1, 8'd1, 8'd0, 8'd6},
                 '{8'd127, 8'd0, 8'd1, 8'd3, 8'd7},
                 '{8'd64, 8'd1, 8'd1, 8'd4, 8'd1},
                 '{8'd5, 8'd0, 8'd0, 8'd2, 8'd3},
                 '{8'd33, 8'd1, 8'd1, 8'd7, 8'd0}};
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    func_i         <= 1'b0;
    address_i      <= '0;
    write_data_i   <= '0;
    video_mode_i   <= '0;
    dma_busy_i     <= 1'b0;
    buttons_i      <= '0;
    divider_high_i <= '0;
    scan_line_i    <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= '0;
    cfg_data_i     <= '0;
    burst_left     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    repeat (240) random_access();
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      for (int i = 0; i < 5; i++) write_reg(cfg_index_e'(i), settings[p][i]);
      repeat (235) random_access();
    end
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // receiver stall patterns, with a long hold-off every so often
  initial begin
    int round;
    round = 0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      round++;
      if (round % 25 == 3) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            out_stall_i <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk_i);
          end
          1: repeat ($urandom_range(4, 30)) begin
            out_stall_i <= 1'($urandom_range(0, 1));
            @(posedge clk_i);
          end
          default: for (int k = 0; k < 24; k++) begin
            out_stall_i <= (k % 3 == 0);
            @(posedge clk_i);
          end
        endcase
      end
    end
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
